// ===== rtl/pow_target_check_defines.svh =====
// assertion macros used by the proof-of-work checker file
`ifndef POW_TARGET_CHECK_DEFINES_SVH
`define POW_TARGET_CHECK_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptc assertion failed");

// next-cycle implication, disabled during reset
`define PTC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptc assertion failed");

`endif

// ===== rtl/ptc_pkg.sv =====
// types, widths and codes shared by the proof-of-work target check
package ptc_pkg;

  localparam int WORD_W     = 64;
  localparam int NWORDS     = 4;
  localparam int HASH_W     = WORD_W * NWORDS;
  localparam int CB_W       = 32;
  localparam int MANT_W     = 23;
  localparam int EXP_W      = 8;
  localparam int IN_DATA_W  = HASH_W + CB_W;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP   = 3'd4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SKIP  = 2'd1,
    ST_RANGE = 2'd2,
    ST_ABOVE = 2'd3
  } status_t;

  // decoded request after the first stage
  typedef struct packed {
    logic              skip;
    logic              bad;
    logic [HASH_W-1:0] target;
    logic [HASH_W-1:0] hash;
  } dec_t;

  // per-word compare flags after the second stage
  typedef struct packed {
    logic              skip;
    logic              bad;
    logic              zero;
    logic [NWORDS-1:0] tl_gt;
    logic [NWORDS-1:0] tl_eq;
    logic [NWORDS-1:0] ht_gt;
    logic [NWORDS-1:0] ht_eq;
  } cmp_t;

endpackage

// ===== rtl/ptc_decode.sv =====
// stage one: compact target decode into a 256-bit target and range flags
module ptc_decode import ptc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  logic [HASH_W-1:0] up_hash,
  input  logic [CB_W-1:0]   up_compact,
  input  logic              skip,
  output logic              dn_valid,
  input  logic              dn_ready,
  output dec_t              dn_dec
);

  logic [EXP_W-1:0]  expo;
  logic [MANT_W-1:0] mant;
  logic              mant_nz;
  logic              neg;
  logic              ovf;
  logic [EXP_W-1:0]  sh_bytes;
  logic [HASH_W-1:0] target;
  logic              valid_r;
  dec_t              dec_r;
  dec_t              dec_nxt;

  assign expo    = up_compact[CB_W-1 -: EXP_W];
  assign mant    = up_compact[MANT_W-1:0];
  assign mant_nz = (mant != '0);
  assign neg     = mant_nz && up_compact[MANT_W];
  assign ovf     = mant_nz && ((expo > 8'd34) ||
                               ((mant > 23'h0000ff) && (expo > 8'd33)) ||
                               ((mant > 23'h00ffff) && (expo > 8'd32)));
  assign sh_bytes = expo - 8'd3;

  always_comb begin
    target = '0;
    if (expo <= 8'd3) begin
      // right shift by whole bytes for tiny exponents
      target = {{(HASH_W-MANT_W){1'b0}}, mant >> {2'd3 - expo[1:0], 3'b000}};
    end else if (expo <= 8'd34) begin
      target = {{(HASH_W-MANT_W){1'b0}}, mant} << {sh_bytes[4:0], 3'b000};
    end
  end

  always_comb begin
    dec_nxt.skip   = skip;
    dec_nxt.bad    = neg | ovf;
    dec_nxt.target = target;
    dec_nxt.hash   = up_hash;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dec_r <= dec_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_dec   = dec_r;

endmodule

// ===== rtl/ptc_compare.sv =====
// stage two: word-wise compares of target against limit and hash against target
module ptc_compare import ptc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  dec_t              up_dec,
  input  logic [HASH_W-1:0] limit,
  output logic              dn_valid,
  input  logic              dn_ready,
  output cmp_t              dn_cmp
);

  logic valid_r;
  cmp_t cmp_r;
  cmp_t cmp_nxt;

  always_comb begin
    cmp_nxt.skip = up_dec.skip;
    cmp_nxt.bad  = up_dec.bad;
    cmp_nxt.zero = (up_dec.target == '0);
    for (int i = 0; i < NWORDS; i++) begin
      cmp_nxt.tl_gt[i] = up_dec.target[i*WORD_W +: WORD_W] > limit[i*WORD_W +: WORD_W];
      cmp_nxt.tl_eq[i] = up_dec.target[i*WORD_W +: WORD_W] == limit[i*WORD_W +: WORD_W];
      cmp_nxt.ht_gt[i] = up_dec.hash[i*WORD_W +: WORD_W] > up_dec.target[i*WORD_W +: WORD_W];
      cmp_nxt.ht_eq[i] = up_dec.hash[i*WORD_W +: WORD_W] == up_dec.target[i*WORD_W +: WORD_W];
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      cmp_r <= cmp_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_cmp   = cmp_r;

endmodule

// ===== rtl/ptc_resolve.sv =====
// stage three: merge word compares into the verdict, holds the output register
module ptc_resolve import ptc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    up_valid,
  output logic    up_ready,
  input  cmp_t    up_cmp,
  output logic    dn_valid,
  input  logic    dn_ready,
  output logic    dn_accepted,
  output status_t dn_status
);

  logic    tgt_above;
  logic    hash_above;
  status_t status_nxt;
  logic    valid_r;
  status_t status_r;

  // lexicographic merge, low word first so the top word decides last
  always_comb begin
    tgt_above  = 1'b0;
    hash_above = 1'b0;
    for (int i = 0; i < NWORDS; i++) begin
      tgt_above  = up_cmp.tl_gt[i] | (up_cmp.tl_eq[i] & tgt_above);
      hash_above = up_cmp.ht_gt[i] | (up_cmp.ht_eq[i] & hash_above);
    end
  end

  always_comb begin
    if (up_cmp.skip) begin
      status_nxt = ST_SKIP;
    end else if (up_cmp.bad || up_cmp.zero || tgt_above) begin
      status_nxt = ST_RANGE;
    end else if (hash_above) begin
      status_nxt = ST_ABOVE;
    end else begin
      status_nxt = ST_OK;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      status_r <= status_nxt;
    end
  end

  assign dn_valid    = valid_r;
  assign dn_status   = status_r;
  assign dn_accepted = (status_r == ST_OK) || (status_r == ST_SKIP);

endmodule

// ===== rtl/pow_target_check.sv =====
// pow_target_check: proof-of-work check of a 256-bit hash against a compact target
//
// in_* carries one request per accepted beat: the hash words and the compact
// target bits. out_* returns one verdict per request, in order: accepted and
// a two-bit status (ok, skipped, target out of range, hash above target).
// cfg_* writes the 256-bit target limit, one 64-bit word per index, and the
// skip flag; cfg_ready is always high, indexes past the skip flag are ignored.
// a request accepted into the decode register moves on through the word
// compare and merge registers and then shows on out_*; the three register
// stages (decode, word compares, merge) each take a new request every cycle
// while out_tready is high, so throughput is then one request per cycle.
// when out_tready is low the stages fill up and in_tready drops once all
// three hold a request; nothing is dropped or repeated.
// reset (rst_n low, synchronous) empties the pipeline, sets the limit to
// all ones and clears the skip flag.
module pow_target_check import ptc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // hash_w0, hash_w1, hash_w2, hash_w3, compact_bits
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // accepted, status, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [WORD_W-1:0]     cfg_data
);

  logic [HASH_W-1:0] limit_r;
  logic              skip_r;
  logic              dec_valid;
  logic              dec_ready;
  dec_t              dec;
  logic              cmp_valid;
  logic              cmp_ready;
  cmp_t              cmp;
  logic              accepted;
  status_t           status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '1;
      skip_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LIMIT0: limit_r[0*WORD_W +: WORD_W] <= cfg_data;
        REG_LIMIT1: limit_r[1*WORD_W +: WORD_W] <= cfg_data;
        REG_LIMIT2: limit_r[2*WORD_W +: WORD_W] <= cfg_data;
        REG_LIMIT3: limit_r[3*WORD_W +: WORD_W] <= cfg_data;
        REG_SKIP:   skip_r <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  ptc_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_tvalid),
    .up_ready   (in_tready),
    .up_hash    (in_tdata[HASH_W-1:0]),
    .up_compact (in_tdata[IN_DATA_W-1:HASH_W]),
    .skip       (skip_r),
    .dn_valid   (dec_valid),
    .dn_ready   (dec_ready),
    .dn_dec     (dec)
  );

  ptc_compare u_compare (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (dec_valid),
    .up_ready (dec_ready),
    .up_dec   (dec),
    .limit    (limit_r),
    .dn_valid (cmp_valid),
    .dn_ready (cmp_ready),
    .dn_cmp   (cmp)
  );

  ptc_resolve u_resolve (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (cmp_valid),
    .up_ready    (cmp_ready),
    .up_cmp      (cmp),
    .dn_valid    (out_tvalid),
    .dn_ready    (out_tready),
    .dn_accepted (accepted),
    .dn_status   (status)
  );

  assign out_tdata = {{(OUT_DATA_W-3){1'b0}}, status, accepted};

endmodule

// ===== rtl/ptc_checker.sv =====
// port-level checks for the proof-of-work target check
`include "pow_target_check_defines.svh"

module ptc_checker import ptc_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic out_pass;

  // status values that must come with accepted set
  assign out_pass = (out_tdata[2:1] == ST_OK) || (out_tdata[2:1] == ST_SKIP);

  `PTC_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `PTC_ASSERT_IMP(a_accept_match, out_tvalid, out_tdata[0] == out_pass)
  `PTC_ASSERT_IMP(a_empty_ready, !out_tvalid, in_tready)
  `PTC_ASSERT_IMP(a_drain_ready, out_tready, in_tready)

endmodule

bind pow_target_check ptc_checker u_ptc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/tb_pow_target_check.sv =====
// self-checking bench for pow_target_check: directed and random requests, inline predictor
`timescale 1ns / 100ps

module tb_pow_target_check;
  import ptc_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 180;
  localparam logic [CFG_IDX_W-1:0] LIMIT_REGS [NWORDS] =
    '{REG_LIMIT0, REG_LIMIT1, REG_LIMIT2, REG_LIMIT3};

  typedef struct packed {
    logic    accepted;
    status_t status;
  } verdict_t;

  typedef struct packed {
    logic              bad;
    logic [HASH_W-1:0] target;
  } target_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [WORD_W-1:0]     cfg_data;

  // local copy of the block's registers
  logic [HASH_W-1:0] limit_cfg;
  logic              skip_cfg;

  verdict_t    verdict_q[$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_cycles;
  bit          send_idle;
  bit          recv_idle;

  pow_target_check u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // compact target decode: byte exponent, sign bit, 23-bit mantissa
  function automatic target_t decode_target(input logic [CB_W-1:0] bits);
    logic [EXP_W-1:0]  ex;
    logic [MANT_W-1:0] mt;
    logic              neg;
    logic              ovf;
    target_t           t;
    ex  = bits[31:24];
    mt  = bits[MANT_W-1:0];
    neg = (mt != 0) && bits[23];
    ovf = (mt != 0) && ((ex > 34) || (mt > 23'hff && ex > 33) || (mt > 23'hffff && ex > 32));
    t.target = '0;
    if (!ovf) begin
      if (ex <= 3) t.target = HASH_W'(mt >> (8 * (3 - ex)));
      else t.target = HASH_W'(mt) << (8 * (ex - 3));
    end
    t.bad = neg || ovf || (t.target == '0);
    return t;
  endfunction

  function automatic verdict_t predict_verdict(input logic [HASH_W-1:0] hash,
                                               input logic [CB_W-1:0] bits);
    target_t  t;
    verdict_t v;
    t = decode_target(bits);
    if (skip_cfg) begin
      v.accepted = 1'b1;
      v.status   = ST_SKIP;
    end else if (t.bad || t.target > limit_cfg) begin
      v.accepted = 1'b0;
      v.status   = ST_RANGE;
    end else if (hash > t.target) begin
      v.accepted = 1'b0;
      v.status   = ST_ABOVE;
    end else begin
      v.accepted = 1'b1;
      v.status   = ST_OK;
    end
    return v;
  endfunction

  function automatic logic [HASH_W-1:0] rand_hash();
    logic [HASH_W-1:0] h;
    for (int i = 0; i < HASH_W / 32; i++) h[i*32 +: 32] = $urandom;
    return h;
  endfunction

  // well-formed bits, retried a few times to land under the current limit
  function automatic logic [CB_W-1:0] draw_fitting_bits();
    logic [EXP_W-1:0]  ex;
    logic [MANT_W-1:0] mt;
    logic [CB_W-1:0]   b;
    target_t           t;
    for (int n = 0; n < 8; n++) begin
      ex = EXP_W'($urandom_range(1, 34));
      mt = MANT_W'($urandom >> $urandom_range(9, 31));
      if (ex == 34) mt &= 23'hff;
      else if (ex == 33) mt &= 23'hffff;
      if (mt == 0) mt = 23'h1;
      b = {ex, 1'b0, mt};
      t = decode_target(b);
      if (!t.bad && t.target <= limit_cfg) break;
    end
    return b;
  endfunction

  function automatic logic [CB_W-1:0] draw_noise_bits();
    logic [CB_W-1:0] b;
    b = $urandom;
    case ($urandom_range(0, 3))
      0: b[23] = 1'b1;
      1: b[MANT_W-1:0] = '0;
      2: b[31:24] = EXP_W'($urandom_range(32, 40));
      default: ;
    endcase
    return b;
  endfunction

  function automatic logic [HASH_W-1:0] hash_near(input logic [HASH_W-1:0] tgt);
    logic [HASH_W-1:0] msk;
    msk = tgt;
    for (int i = 1; i < HASH_W; i = i << 1) msk |= msk >> i;
    case ($urandom_range(0, 5))
      0: return tgt;
      1: return tgt + 1;
      2: return tgt - $urandom_range(0, 1000);
      3: return rand_hash() & msk;
      4: return rand_hash() >> $urandom_range(0, HASH_W - 1);
      default: return rand_hash();
    endcase
  endfunction

  task automatic send_request(input logic [HASH_W-1:0] hash, input logic [CB_W-1:0] bits);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {bits, hash};
    do @(posedge clk); while (!in_tready);
    verdict_q.push_back(predict_verdict(hash, bits));
  endtask

  task automatic wait_all_verdicts();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    wait_all_verdicts();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LIMIT0: limit_cfg[0*WORD_W +: WORD_W] = val;
      REG_LIMIT1: limit_cfg[1*WORD_W +: WORD_W] = val;
      REG_LIMIT2: limit_cfg[2*WORD_W +: WORD_W] = val;
      REG_LIMIT3: limit_cfg[3*WORD_W +: WORD_W] = val;
      REG_SKIP:   skip_cfg = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_limit(input logic [HASH_W-1:0] lim);
    for (int w = 0; w < NWORDS; w++) write_setting(LIMIT_REGS[w], lim[w*WORD_W +: WORD_W]);
  endtask

  // decode corners under the all-ones limit left by reset
  task automatic test_target_decoding();
    send_request('0, 32'h0000_0000);
    send_request('0, 32'h0480_0000);
    send_request('0, 32'h0480_0001);
    send_request('0, 32'h0280_8000);
    send_request('0, 32'h2300_0001);
    send_request('0, 32'h2200_0100);
    send_request('1, 32'h2200_00ff);
    send_request(256'hff << 248, 32'h2200_00ff);
    send_request('0, 32'h2101_0000);
    send_request('0, 32'h2100_ffff);
    send_request('1, 32'h207f_ffff);
    send_request(256'h7f_ffff << 232, 32'h207f_ffff);
    send_request('0, 32'h007f_ffff);
    send_request(256'h7f, 32'h017f_ffff);
    send_request(256'h80, 32'h017f_ffff);
    send_request(256'h0, 32'h0300_0001);
    send_request(256'h1, 32'h0300_0001);
    send_request(256'h2, 32'h0300_0001);
    send_request('0, 32'hff00_0000);
    send_request('0, 32'hffff_ffff);
    send_request(256'hffff << 200, 32'h1d00_ffff);
    send_request('1, 32'h1d00_ffff);
    send_request('1, 32'h047f_ffff);
  endtask

  task automatic test_limit_registers();
    logic [CFG_IDX_W-1:0] idx;
    // writes past the skip flag must leave everything alone
    for (int k = int'(REG_SKIP) + 1; k < (1 << CFG_IDX_W); k++) begin
      idx = k[CFG_IDX_W-1:0];
      write_setting(idx, {$urandom, $urandom});
    end
    send_request('0, 32'h2200_00ff);
    send_request('0, 32'h0300_0001);
    set_limit(256'hffff << 208);
    send_request('0, 32'h1d00_ffff);
    send_request('0, 32'h1d01_0000);
    send_request('0, 32'h1e00_ffff);
    send_request('0, 32'h1c7f_ffff);
    send_request((256'h7f_ffff << 200) + 1, 32'h1c7f_ffff);
    set_limit(256'h1 << 64);
    send_request('0, 32'h0b00_0001);
    send_request('0, 32'h0b00_0002);
    send_request('0, 32'h0a00_ffff);
    set_limit('0);
    send_request('0, 32'h0300_0001);
    send_request('0, 32'h2200_00ff);
    set_limit('1);
  endtask

  task automatic test_skip_flag();
    write_setting(REG_SKIP, {$urandom, $urandom} | 64'h1);
    for (int n = 0; n < 20; n++) send_request(rand_hash(), $urandom);
    send_request('1, 32'h0000_0000);
    write_setting(REG_SKIP, {$urandom, $urandom} & ~64'h1);
    for (int n = 0; n < 20; n++) send_request(rand_hash(), draw_noise_bits());
  endtask

  // long receiver hold while the sender keeps pushing
  task automatic test_output_backpressure();
    logic [CB_W-1:0] bits;
    target_t         t;
    send_idle   = 1'b0;
    hold_cycles = 150;
    for (int n = 0; n < 40; n++) begin
      bits = draw_fitting_bits();
      t    = decode_target(bits);
      send_request(hash_near(t.target), bits);
    end
    wait_all_verdicts();
    send_idle = 1'b1;
  endtask

  task automatic test_random_checks();
    logic [HASH_W-1:0] lim;
    logic [CB_W-1:0]   bits;
    target_t           t;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: lim = '1;
        1: lim = 256'hffff << 208;
        3: lim = rand_hash() >> $urandom_range(0, HASH_W - 1);
        default: begin
          for (int w = 0; w < NWORDS; w++) begin
            case ($urandom_range(0, 2))
              0: lim[w*WORD_W +: WORD_W] = '0;
              1: lim[w*WORD_W +: WORD_W] = '1;
              default: lim[w*WORD_W +: WORD_W] = {$urandom, $urandom};
            endcase
          end
        end
      endcase
      set_limit(lim);
      send_idle = (ph == 0 || ph == 2) ? 1'b1 :
                  (ph == 1 || ph == 3) ? 1'b0 : 1'($urandom_range(0, 1));
      recv_idle = (ph == 0 || ph == 3) ? 1'b1 :
                  (ph == 1 || ph == 2) ? 1'b0 : 1'($urandom_range(0, 1));
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        if ($urandom_range(0, 3) != 0) begin
          bits = draw_fitting_bits();
          t    = decode_target(bits);
          send_request(hash_near(t.target), bits);
        end else begin
          send_request(rand_hash(), draw_noise_bits());
        end
      end
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  initial begin : result_checker
    int unsigned stall;
    verdict_t    want;
    verdict_t    got;
    out_tready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_cycles != 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = recv_idle ? $urandom_range(0, 9) : 0;
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got.accepted = out_tdata[0];
      got.status   = status_t'(out_tdata[2:1]);
      if (verdict_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected verdict, expected none actual accepted=%0b status=%0d",
                 $time, got.accepted, got.status);
      end else begin
        want = verdict_q.pop_front();
        if (got.accepted !== want.accepted) begin
          fail_count++;
          $display("%0t: accepted mismatch, expected %0b actual %0b",
                   $time, want.accepted, got.accepted);
        end
        if (got.status !== want.status) begin
          fail_count++;
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, want.status, got.status);
        end
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    limit_cfg   = '1;
    skip_cfg    = 1'b0;
    hold_cycles = 0;
    send_idle   = 1'b1;
    recv_idle   = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_target_decoding();
    test_limit_registers();
    test_skip_flag();
    test_output_backpressure();
    test_random_checks();
    wait_all_verdicts();
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
